FILE: src/lsq_pkg.sv
// ---------------------------------------------------------------------------
// lsq_pkg - shared types and constants for the largest square unit
// Widths of the line store, column counter and result fields, plus the
// control bundle that drives the line of side-value cells.
// ---------------------------------------------------------------------------
package lsq_pkg;

	// largest row the line store can hold
	localparam int MAX_WIDTH = 1024;

	// field widths
	localparam int SIDE_W  = 11;
	localparam int AREA_W  = 21;
	localparam int WIDTH_W = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);

	typedef logic [SIDE_W-1:0] side_t;
	typedef logic [COL_W-1:0]  col_t;

	// control bundle from the top level to the line of cells
	typedef struct packed {
		logic shift;  // advance the line by one place
		col_t tail;   // place where the newest side value enters
	} line_ctl_t;

endpackage

FILE: src/lsq_cell.sv
// ---------------------------------------------------------------------------
// lsq_cell - one place of the line store
// Holds one side value; on a shift it either takes the new value (when it
// is the entry place for the current row width) or its neighbour's value.
// ---------------------------------------------------------------------------
module lsq_cell
	import lsq_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  logic  load,
	input  side_t ins_data,
	input  side_t nxt_data,
	output side_t data
);

	side_t data_q;

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= load ? ins_data : nxt_data;
		end
	end

	assign data = data_q;

endmodule

FILE: src/lsq_line.sv
// ---------------------------------------------------------------------------
// lsq_line - line store built as a chain of cells
// New side values enter at the place given by the row width and move one
// place towards the head per transfer, so the head holds the value written
// exactly one row earlier.
// ---------------------------------------------------------------------------
module lsq_line
	import lsq_pkg::*;
(
	input  logic      clk,
	input  line_ctl_t ctl,
	input  side_t     ins_data,
	output side_t     up_data
);

	side_t cell_data [MAX_WIDTH];

	// the row of cells
	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		side_t nxt;

		if (i == MAX_WIDTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		lsq_cell u_cell (
			.clk      (clk),
			.shift    (ctl.shift),
			.load     (ctl.tail == COL_W'(i)),
			.ins_data (ins_data),
			.nxt_data (nxt),
			.data     (cell_data[i])
		);
	end

	// head of the line is the value above the current pixel
	assign up_data = cell_data[0];

endmodule

FILE: src/lsq_pe.sv
// ---------------------------------------------------------------------------
// lsq_pe - side-value processing element
// Works out the square side at the current pixel from the up, left and
// diagonal neighbours, keeps the column position, first-row flag and the
// best side of the frame.
// ---------------------------------------------------------------------------
module lsq_pe
	import lsq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  logic  clear,
	input  logic  pixel,
	input  logic  last_pixel,
	input  col_t  tail,
	input  side_t up_raw,
	output side_t side_new,
	output side_t best_next
);

	col_t  col_q;
	side_t left_q;
	side_t diag_q;
	side_t best_q;
	logic  first_row_q;

	side_t up, left, diag, m_ul, m_all;
	logic  row_start;

	// neighbours, zero outside the image
	always_comb begin
		row_start = (col_q == '0);
		up        = first_row_q ? '0 : up_raw;
		left      = row_start ? '0 : left_q;
		diag      = (first_row_q || row_start) ? '0 : diag_q;
		m_ul      = (up < left) ? up : left;
		m_all     = (m_ul < diag) ? m_ul : diag;
		side_new  = pixel ? m_all + side_t'(1) : '0;
		best_next = (side_new > best_q) ? side_new : best_q;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_q      <= '0;
			first_row_q <= 1'b1;
		end else if (clear || (accept && last_pixel)) begin
			col_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_q      <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			diag_q <= up;
			left_q <= side_new;
			best_q <= best_next;
			if (col_q >= tail) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

`ifndef SYNTH
	// frame state is cleared after the last pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_pixel |=> best_q == '0 && col_q == '0 && first_row_q)
		else $error("frame state not cleared after last pixel");

	// column never passes the end of the row
	assert property (@(posedge clk) disable iff (!arst_n) col_q <= tail)
		else $error("column beyond row end");

	// a square cannot be wider than the columns up to and including its own
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> {1'b0, side_new} <= {1'b0, col_q} + (SIDE_W+1)'(1))
		else $error("side exceeds column position");
`endif

endmodule

FILE: src/largest_square_of_ones_unit.sv
// ---------------------------------------------------------------------------
// largest_square_of_ones_unit - largest all-ones square in a binary image
// Pixels in raster order, one per transfer; on the last pixel of a frame
// the side and area of the largest square of set pixels are returned.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    pixel, last_pixel
//   result   out        out_valid/out_ready  side, area
//   config   in         cfg_wr_en            cfg_wr_data (image width)
//
// One pixel per clock unless stalled, limited by the side-value loop.
// A registered result follows in the cycle after the last pixel's transfer.
// Input is stalled only while a result waits and out_ready is low.
// Reset clears the frame state and sets the row width to 1024; no clearing
// pass, the line store is always written one row before it is read.
// A width write restarts the frame.
// ---------------------------------------------------------------------------
module largest_square_of_ones_unit
	import lsq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [WIDTH_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               pixel,
	input  logic               last_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SIDE_W-1:0]  side,
	output logic [AREA_W-1:0]  area
);

	col_t      tail_q;
	col_t      tail_new;
	line_ctl_t line_ctl;
	side_t     up_raw, side_new, best_next;
	logic      in_xfer;
	logic      res_valid_q;
	side_t     res_side_q;
	logic [2*SIDE_W-1:0] area_full;

	assign in_ready = !res_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// row width, kept as the index of the last column
	always_comb begin
		if (cfg_wr_data == '0) begin
			tail_new = '0;
		end else if (cfg_wr_data > WIDTH_W'(MAX_WIDTH)) begin
			tail_new = col_t'(MAX_WIDTH - 1);
		end else begin
			tail_new = COL_W'(cfg_wr_data - WIDTH_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= col_t'(MAX_WIDTH - 1);
		end else if (cfg_wr_en) begin
			tail_q <= tail_new;
		end
	end

	// line store
	assign line_ctl.shift = in_xfer;
	assign line_ctl.tail  = tail_q;

	lsq_line u_line (
		.clk      (clk),
		.ctl      (line_ctl),
		.ins_data (side_new),
		.up_data  (up_raw)
	);

	// side-value element
	lsq_pe u_pe (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_xfer),
		.clear      (cfg_wr_en),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.tail       (tail_q),
		.up_raw     (up_raw),
		.side_new   (side_new),
		.best_next  (best_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer && last_pixel) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && last_pixel) begin
			res_side_q <= best_next;
		end
	end

	// area from the registered side
	assign area_full = res_side_q * res_side_q;
	assign out_valid = res_valid_q;
	assign side      = res_side_q;
	assign area      = area_full[AREA_W-1:0];

`ifndef SYNTH
	// a last-pixel transfer always yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_pixel |=> out_valid)
		else $error("missing result after last pixel");
`endif

endmodule

FILE: dv/largest_square_of_ones_unit_test.sv
// ---------------------------------------------------------------------------
// largest_square_of_ones_unit_test - self-checking bench for the square unit
// Streams binary frames into the unit at a range of row widths and checks
// each returned side and area against a software copy of the square-side
// recurrence. Both channels idle at random, the receiver once holds off
// long enough to stall the input, and width writes land between frames
// and part-way through a frame.
// ---------------------------------------------------------------------------
module largest_square_of_ones_unit_test;
	import lsq_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int ITEM_TARGET  = 850;
	localparam int SETTLE       = 4;

	typedef struct {
		logic [SIDE_W-1:0] side;
		logic [AREA_W-1:0] area;
	} square_result_t;

	// predicts the largest square per frame and checks returned results
	class square_scoreboard;
		logic [WIDTH_W-1:0] width_reg;
		logic [SIDE_W-1:0]  row_sides[MAX_WIDTH];
		int                 col;
		logic [SIDE_W-1:0]  left_side;
		logic [SIDE_W-1:0]  diag_side;
		logic [SIDE_W-1:0]  best;
		bit                 first_row;
		square_result_t     pending[$];
		int                 errors;

		function new();
			width_reg = WIDTH_W'(MAX_WIDTH);
			errors = 0;
			foreach (row_sides[i]) row_sides[i] = '0;
			restart_frame();
		endfunction

		function void restart_frame();
			col = 0;
			left_side = '0;
			diag_side = '0;
			best = '0;
			first_row = 1'b1;
		endfunction

		function void set_width(logic [WIDTH_W-1:0] w);
			width_reg = w;
			restart_frame();
		endfunction

		// zero counts as one, anything past the store saturates
		function int row_len();
			int w;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			return w;
		endfunction

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		// one accepted pixel transfer
		function void note_pixel(logic p, logic l);
			int                w;
			logic [SIDE_W-1:0] up, lft, dg, s;
			square_result_t    r;
			w = row_len();
			if (col >= w) col = 0;
			up  = first_row ? '0 : row_sides[col];
			lft = (col == 0) ? '0 : left_side;
			dg  = (first_row || col == 0) ? '0 : diag_side;
			if (p) begin
				s = up;
				if (lft < s) s = lft;
				if (dg < s) s = dg;
				s = s + 1'b1;
			end else begin
				s = '0;
			end
			diag_side = up;
			row_sides[col] = s;
			left_side = s;
			if (s > best) best = s;
			col++;
			if (col >= w) begin
				col = 0;
				first_row = 1'b0;
			end
			if (l) begin
				r.side = best;
				r.area = AREA_W'(int'(best) * int'(best));
				pending.push_back(r);
				restart_frame();
			end
		endfunction

		// one accepted result transfer
		function void check_result(logic [SIDE_W-1:0] s, logic [AREA_W-1:0] a);
			square_result_t exp_r;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending: side %0d area %0d", s, a));
				return;
			end
			exp_r = pending.pop_front();
			if (s !== exp_r.side)
				report($sformatf("side %0d, predicted %0d", s, exp_r.side));
			if (a !== exp_r.area)
				report($sformatf("area %0d, predicted %0d", a, exp_r.area));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [WIDTH_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               pixel;
	logic               last_pixel;
	logic               out_valid;
	logic               out_ready;
	logic [SIDE_W-1:0]  side;
	logic [AREA_W-1:0]  area;

	square_scoreboard sb = new();
	int  sent_items;
	int  cycle_count;
	int  hold_off_len;
	bit  src_steady;
	bit  sink_steady;

	largest_square_of_ones_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.side       (side),
		.area       (area)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// watch both channels for transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pixel(pixel, last_pixel);
			if (out_valid && out_ready)
				sb.check_result(side, area);
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(20, 60);
	endfunction

	// result receiver: random stalls, steady stretches, one long hold-off on request
	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_steady || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// offer one pixel and wait for its transfer
	task automatic send_pixel(input logic p, input logic l);
		in_valid   <= 1'b1;
		pixel      <= p;
		last_pixel <= l;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// a run of random pixels, optionally closed by the frame's last pixel
	task automatic send_run(input int n, input int ones_pct, input bit with_last);
		for (int i = 0; i < n; i++) begin
			send_pixel($urandom_range(0, 99) < ones_pct, with_last && (i == n - 1));
			if (!src_steady && $urandom_range(0, 5) == 0)
				idle_gap(gap_len());
		end
	endtask

	// fixed pattern, first pixel in bit 0, last pixel flagged
	task automatic send_pattern(input logic [15:0] bits, input int n);
		for (int i = 0; i < n; i++)
			send_pixel(bits[i], i == n - 1);
	endtask

	// stop offering and wait for every predicted result, then let the unit settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] w);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		sb.set_width(w);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WIDTH_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return WIDTH_W'($urandom_range(1, 12));
		if (r < 85) return WIDTH_W'($urandom_range(13, 64));
		if (r < 92) return '0;
		return WIDTH_W'($urandom_range(65, 2047));
	endfunction

	function automatic int pick_density();
		case ($urandom_range(0, 3))
			0: return 50;
			1: return 85;
			2: return 97;
			default: return 100;
		endcase
	endfunction

	// frame length: up to six rows for narrow images, at most 100 pixels for wide ones
	function automatic int pick_length();
		int w;
		w = sb.row_len();
		if (w > 64) return $urandom_range(1, 100);
		return $urandom_range(1, w * 6);
	endfunction

	// stimulus
	initial begin
		int phase;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		pixel       <= 1'b0;
		last_pixel  <= 1'b0;
		src_steady  = 1'b1;
		sink_steady = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pixel frames at the reset width
		send_pattern(16'b1, 1);
		send_pattern(16'b0, 1);
		drain();
		// width zero behaves as a single column
		write_width('0);
		send_pattern(16'b0111, 4);
		drain();
		// full 3x3 block, row starts must not see the previous row's end
		write_width(WIDTH_W'(3));
		send_pattern(16'b1_1111_1111, 9);
		drain();
		// frame ending part-way through a row
		write_width(WIDTH_W'(2));
		send_pattern(16'b111, 3);
		drain();
		// width write in the middle of a frame restarts it
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b0);
		drain();
		write_width('1);
		send_pattern(16'b1, 1);
		drain();

		// receiver holds off while short frames keep coming, input must stall
		write_width(WIDTH_W'(2));
		src_steady = 1'b1;
		hold_off_len = 80;
		repeat (8) send_run(3, 100, 1'b1);
		drain();

		// random phases
		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			phase++;
			src_steady  = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			drain();
			if (phase == 3) begin
				// wide row, a little over one row of set pixels
				write_width(WIDTH_W'($urandom_range(200, 300)));
				send_run(sb.row_len() + $urandom_range(1, 60), 100, 1'b1);
			end else if (phase == 6) begin
				// width beyond the store saturates
				write_width(WIDTH_W'($urandom_range(MAX_WIDTH + 1, 2047)));
				send_run($urandom_range(1, 100), 97, 1'b1);
			end else begin
				write_width(pick_width());
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 7) == 0) begin
						// abandoned frame, then a new width
						send_run(pick_length(), pick_density(), 1'b0);
						drain();
						write_width(pick_width());
					end
					send_run(pick_length(), pick_density(), 1'b1);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: largest_square_of_ones_unit.f
src/lsq_pkg.sv
src/lsq_cell.sv
src/lsq_line.sv
src/lsq_pe.sv
src/largest_square_of_ones_unit.sv
dv/largest_square_of_ones_unit_test.sv
